// ===== rtl/rrqs_pkg.sv =====
`default_nettype none

package rrqs_pkg;

	localparam int TASK_SLOTS = 16;
	localparam int SLOT_W     = (TASK_SLOTS > 1) ? $clog2(TASK_SLOTS) : 1;
	localparam int CNT_W      = $clog2(TASK_SLOTS + 1);
	localparam int IN_SLOT_W  = 4;
	localparam int IDX_W      = 4;
	localparam int MODE_W     = 2;
	localparam int QUANT_W    = 8;
	localparam int CMP_W      = (CNT_W > IN_SLOT_W) ? CNT_W : IN_SLOT_W;

	localparam logic [QUANT_W-1:0] QUANT_RST  = QUANT_W'(10);
	localparam logic [CNT_W-1:0]   SLOTS_CNT  = CNT_W'(TASK_SLOTS);

	typedef enum logic [MODE_W-1:0] {
		MODE_TICK = 2'd0,
		MODE_ADD  = 2'd1,
		MODE_SET  = 2'd2
	} mode_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_EXEC,
		ST_SCAN,
		ST_RESP
	} state_t;

	typedef struct packed {
		logic [MODE_W-1:0]    mode;
		logic [IN_SLOT_W-1:0] slot;
		logic                 ready_flag;
	} item_t;

	typedef struct packed {
		logic [IDX_W-1:0] task_index;
		logic             dispatched;
		logic             none_ready;
		logic             rejected;
	} res_t;

	function automatic logic [SLOT_W-1:0] next_slot(
		input logic [SLOT_W-1:0] s,
		input logic [CNT_W-1:0]  cnt
	);
		logic [CNT_W-1:0] inc;
		inc = CNT_W'(s) + CNT_W'(1);
		return (inc >= cnt) ? '0 : inc[SLOT_W-1:0];
	endfunction

	function automatic logic [IDX_W-1:0] to_idx(input logic [SLOT_W-1:0] s);
		logic [SLOT_W+IDX_W-1:0] w;
		w = (SLOT_W + IDX_W)'(s);
		return w[IDX_W-1:0];
	endfunction

	function automatic logic [SLOT_W-1:0] to_addr(input logic [IN_SLOT_W-1:0] s);
		logic [SLOT_W+IN_SLOT_W-1:0] w;
		w = (SLOT_W + IN_SLOT_W)'(s);
		return w[SLOT_W-1:0];
	endfunction

endpackage

`default_nettype wire

// ===== rtl/rrqs_ram.sv =====
`default_nettype none

module rrqs_ram #(
	parameter int WIDTH = 1,
	parameter int DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

`default_nettype wire

// ===== rtl/rrqs_ctrl.sv =====
`default_nettype none

module rrqs_ctrl (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          in_valid,
	output logic                               in_ready,
	input  wire rrqs_pkg::item_t               item,
	input  wire logic [rrqs_pkg::QUANT_W-1:0]  quantum,
	output logic                               res_valid,
	input  wire logic                          res_ready,
	output rrqs_pkg::res_t                     res
);

	rrqs_pkg::state_t state_q, state_d;

	logic [rrqs_pkg::MODE_W-1:0]    mode_q;
	logic [rrqs_pkg::IN_SLOT_W-1:0] slot_q;
	logic                           flag_q;
	logic [rrqs_pkg::CNT_W-1:0]     count_q, count_d;
	logic [rrqs_pkg::SLOT_W-1:0]    cur_q, cur_d;
	logic [rrqs_pkg::QUANT_W-1:0]   ticks_q, ticks_d;
	logic [rrqs_pkg::SLOT_W-1:0]    scan_q, scan_d;
	logic [rrqs_pkg::CNT_W-1:0]     iss_q, iss_d;
	logic [rrqs_pkg::CNT_W-1:0]     chk_q, chk_d;
	logic                           pend_s1, pend_d;
	logic [rrqs_pkg::SLOT_W-1:0]    addr_s1;
	rrqs_pkg::res_t                 res_q, res_d;

	logic                           ram_we;
	logic [rrqs_pkg::SLOT_W-1:0]    ram_waddr;
	logic                           ram_wdata;
	logic                           ram_rdata;
	logic [rrqs_pkg::SLOT_W-1:0]    start_slot;

	rrqs_ram #(
		.WIDTH(1),
		.DEPTH(rrqs_pkg::TASK_SLOTS)
	) u_ready_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (scan_q),
		.rdata (ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= rrqs_pkg::ST_IDLE;
			count_q <= '0;
			cur_q   <= '0;
			ticks_q <= rrqs_pkg::QUANT_RST;
			pend_s1 <= 1'b0;
		end else begin
			state_q <= state_d;
			count_q <= count_d;
			cur_q   <= cur_d;
			ticks_q <= ticks_d;
			pend_s1 <= pend_d;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			mode_q <= item.mode;
			slot_q <= item.slot;
			flag_q <= item.ready_flag;
		end
		scan_q  <= scan_d;
		iss_q   <= iss_d;
		chk_q   <= chk_d;
		addr_s1 <= scan_q;
		res_q   <= res_d;
	end

	always_comb begin
		state_d    = state_q;
		count_d    = count_q;
		cur_d      = cur_q;
		ticks_d    = ticks_q;
		scan_d     = scan_q;
		iss_d      = iss_q;
		chk_d      = chk_q;
		pend_d     = 1'b0;
		res_d      = res_q;
		ram_we     = 1'b0;
		ram_waddr  = count_q[rrqs_pkg::SLOT_W-1:0];
		ram_wdata  = flag_q;
		start_slot = cur_q;
		in_ready   = 1'b0;
		res_valid  = 1'b0;

		case (state_q)
			rrqs_pkg::ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					state_d = rrqs_pkg::ST_EXEC;
				end
			end
			rrqs_pkg::ST_EXEC: begin
				res_d   = '0;
				state_d = rrqs_pkg::ST_RESP;
				case (mode_q)
					rrqs_pkg::MODE_TICK: begin
						if (count_q != '0) begin
							if (ticks_q <= rrqs_pkg::QUANT_W'(1)) begin
								ticks_d    = quantum;
								start_slot = rrqs_pkg::next_slot(cur_q, count_q);
							end else begin
								ticks_d = ticks_q - rrqs_pkg::QUANT_W'(1);
							end
							cur_d   = start_slot;
							scan_d  = start_slot;
							iss_d   = '0;
							chk_d   = '0;
							state_d = rrqs_pkg::ST_SCAN;
						end
					end
					rrqs_pkg::MODE_ADD: begin
						if (count_q < rrqs_pkg::SLOTS_CNT) begin
							ram_we           = 1'b1;
							res_d.task_index = rrqs_pkg::to_idx(count_q[rrqs_pkg::SLOT_W-1:0]);
							count_d          = count_q + rrqs_pkg::CNT_W'(1);
						end else begin
							res_d.rejected = 1'b1;
						end
					end
					rrqs_pkg::MODE_SET: begin
						res_d.task_index = rrqs_pkg::IDX_W'(slot_q);
						ram_waddr        = rrqs_pkg::to_addr(slot_q);
						if (rrqs_pkg::CMP_W'(slot_q) < rrqs_pkg::CMP_W'(count_q)) begin
							ram_we = 1'b1;
						end else begin
							res_d.rejected = 1'b1;
						end
					end
					default: begin
					end
				endcase
			end
			rrqs_pkg::ST_SCAN: begin
				if (iss_q < count_q) begin
					pend_d = 1'b1;
					scan_d = rrqs_pkg::next_slot(scan_q, count_q);
					iss_d  = iss_q + rrqs_pkg::CNT_W'(1);
				end
				if (pend_s1) begin
					chk_d = chk_q + rrqs_pkg::CNT_W'(1);
					if (ram_rdata) begin
						cur_d            = addr_s1;
						res_d.task_index = rrqs_pkg::to_idx(addr_s1);
						res_d.dispatched = 1'b1;
						pend_d           = 1'b0;
						state_d          = rrqs_pkg::ST_RESP;
					end else if (chk_q + rrqs_pkg::CNT_W'(1) == count_q) begin
						res_d.task_index = rrqs_pkg::to_idx(cur_q);
						res_d.none_ready = 1'b1;
						pend_d           = 1'b0;
						state_d          = rrqs_pkg::ST_RESP;
					end
				end
			end
			rrqs_pkg::ST_RESP: begin
				res_valid = 1'b1;
				if (res_ready) begin
					state_d = rrqs_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = rrqs_pkg::ST_IDLE;
			end
		endcase
	end

	assign res = res_q;

endmodule

`default_nettype wire

// ===== rtl/round_robin_quantum_scheduler.sv =====
// Round-robin time-slice scheduler over a table of task slots.
// Input channel (in_valid/in_ready, mode, slot, ready_flag): one item per
// transfer; tick, add task or set a slot's ready flag. Each item yields one
// result on the output channel (out_valid/out_ready, task_index, dispatched,
// none_ready, rejected).
// Config channel (cfg_valid/cfg_ready, quantum_ticks) loads the quantum;
// cfg_ready is always high; a new quantum applies at the next reload.
// Add and set pass ST_EXEC and ST_RESP, then enter the output register.
// A tick scans the ready-flag RAM one slot per cycle (one read port,
// registered read) in ST_SCAN until the first ready slot is found or all
// task_count slots have been checked, then the result goes to ST_RESP.
// One item is in flight at a time; in_ready returns once the result has
// moved into the output register, so the next item is taken while that
// result still waits for out_ready.
// Reset: table empty, current slot 0, countdown and quantum 10; the slot
// RAM needs no clearing since only slots below the task count are read.
// A stalled receiver holds the output register; a further result waits in
// the controller and no new input is taken until it moves on.
`default_nettype none

module round_robin_quantum_scheduler (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                in_valid,
	output logic                                     in_ready,
	input  wire logic [rrqs_pkg::MODE_W-1:0]         mode,
	input  wire logic [rrqs_pkg::IN_SLOT_W-1:0]      slot,
	input  wire logic                                ready_flag,
	output logic                                     out_valid,
	input  wire logic                                out_ready,
	output logic [rrqs_pkg::IDX_W-1:0]               task_index,
	output logic                                     dispatched,
	output logic                                     none_ready,
	output logic                                     rejected,
	input  wire logic                                cfg_valid,
	output logic                                     cfg_ready,
	input  wire logic [rrqs_pkg::QUANT_W-1:0]        quantum_ticks
);

	logic [rrqs_pkg::QUANT_W-1:0] quantum_q;
	rrqs_pkg::item_t              item;
	rrqs_pkg::res_t               res;
	rrqs_pkg::res_t               out_q;
	logic                         out_valid_q;
	logic                         res_valid;
	logic                         res_ready;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			quantum_q <= rrqs_pkg::QUANT_RST;
		end else if (cfg_valid && cfg_ready) begin
			quantum_q <= quantum_ticks;
		end
	end

	assign item.mode       = mode;
	assign item.slot       = slot;
	assign item.ready_flag = ready_flag;

	rrqs_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.item      (item),
		.quantum   (quantum_q),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.res       (res)
	);

	assign res_ready = !out_valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_ready) begin
			out_valid_q <= res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid && res_ready) begin
			out_q <= res;
		end
	end

	assign out_valid  = out_valid_q;
	assign task_index = out_q.task_index;
	assign dispatched = out_q.dispatched;
	assign none_ready = out_q.none_ready;
	assign rejected   = out_q.rejected;

	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("input taken while an item is in flight");

	a_flags_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> $onehot0({dispatched, none_ready, rejected}))
		else $error("more than one result flag set");

	a_result_lands: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_ready |=> out_valid && !res_valid)
		else $error("result transfer lost or repeated");

endmodule

`default_nettype wire

// ===== tb/sv/round_robin_quantum_scheduler_tb.sv =====
`timescale 1ns / 100ps

module round_robin_quantum_scheduler_tb;

	import rrqs_pkg::*;

	localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;
	localparam int IDLE_LIMIT = 4000;
	localparam int TAIL_CYCLES = 30;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic [MODE_W-1:0] mode = MODE_TICK;
	logic [IN_SLOT_W-1:0] slot = '0;
	logic ready_flag = 1'b0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic [IDX_W-1:0] task_index;
	logic dispatched;
	logic none_ready;
	logic rejected;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [QUANT_W-1:0] quantum_ticks = QUANT_RST;

	logic burst_mode = 1'b0;
	int stall_left = 0;
	int idle_cycles = 0;
	int error_count = 0;

	// scheduler shadow state
	logic [QUANT_W-1:0] quantum_q = QUANT_RST;
	logic [CNT_W-1:0] task_cnt = '0;
	logic [SLOT_W-1:0] cur_slot = '0;
	logic [QUANT_W-1:0] ticks_left = QUANT_RST;
	logic slot_rdy [TASK_SLOTS] = '{default: 1'b0};

	res_t due_replies [$];

	round_robin_quantum_scheduler i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.mode(mode),
		.slot(slot),
		.ready_flag(ready_flag),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.task_index(task_index),
		.dispatched(dispatched),
		.none_ready(none_ready),
		.rejected(rejected),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.quantum_ticks(quantum_ticks)
	);

	always #10 clk = ~clk;

	function automatic logic [SLOT_W-1:0] wrap_next(input logic [SLOT_W-1:0] s);
		return ((CNT_W'(s) + CNT_W'(1)) >= task_cnt) ? '0 : s + SLOT_W'(1);
	endfunction

	function automatic res_t predict_schedule(input item_t it);
		res_t r;
		logic [SLOT_W-1:0] s;
		logic found;
		r = '0;
		case (it.mode)
			MODE_TICK: begin
				if (task_cnt != 0) begin
					if (ticks_left <= 1) begin
						ticks_left = quantum_q;
						cur_slot = wrap_next(cur_slot);
					end else begin
						ticks_left = ticks_left - 1'b1;
					end
					s = cur_slot;
					found = 1'b0;
					for (int n = 0; n < task_cnt; n++) begin
						if (!found) begin
							if (slot_rdy[s])
								found = 1'b1;
							else
								s = wrap_next(s);
						end
					end
					if (found) begin
						cur_slot = s;
						r.dispatched = 1'b1;
						r.task_index = IDX_W'(s);
					end else begin
						r.none_ready = 1'b1;
						r.task_index = IDX_W'(cur_slot);
					end
				end
			end
			MODE_ADD: begin
				if (task_cnt < TASK_SLOTS) begin
					slot_rdy[task_cnt[SLOT_W-1:0]] = it.ready_flag;
					r.task_index = IDX_W'(task_cnt);
					task_cnt = task_cnt + 1'b1;
				end else begin
					r.rejected = 1'b1;
				end
			end
			MODE_SET: begin
				r.task_index = it.slot;
				if (CNT_W'(it.slot) < task_cnt)
					slot_rdy[it.slot] = it.ready_flag;
				else
					r.rejected = 1'b1;
			end
			default: r = '0;
		endcase
		return r;
	endfunction

	function automatic item_t make_item(input logic [MODE_W-1:0] m,
			input logic [IN_SLOT_W-1:0] s, input logic f);
		item_t it;
		it.mode = m;
		it.slot = s;
		it.ready_flag = f;
		return it;
	endfunction

	function automatic int pick_delay();
		int r;
		r = $urandom_range(0, 99);
		if (burst_mode || r < 50)
			return 0;
		if (r < 85)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 20);
		return $urandom_range(21, 50);
	endfunction

	task automatic report_mismatch(input string what, input int got, input int want);
		$display("%0t: %s got %0d expected %0d", $time, what, got, want);
		error_count++;
	endtask

	task automatic send_item(input item_t it);
		int gap;
		in_valid <= 1'b1;
		mode <= it.mode;
		slot <= it.slot;
		ready_flag <= it.ready_flag;
		do @(posedge clk); while (!in_ready);
		due_replies.push_back(predict_schedule(it));
		gap = pick_delay();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic wait_drained(input int settle);
		in_valid <= 1'b0;
		while (due_replies.size() != 0)
			@(posedge clk);
		repeat (settle + 1) @(posedge clk);
	endtask

	task automatic write_quantum(input logic [QUANT_W-1:0] q);
		wait_drained(4);
		cfg_valid <= 1'b1;
		quantum_ticks <= q;
		do @(posedge clk); while (!cfg_ready);
		quantum_q = q;
		cfg_valid <= 1'b0;
	endtask

	task automatic test_empty_table();
		send_item(make_item(MODE_TICK, 4'd0, 1'b0));
		send_item(make_item(MODE_TICK, 4'd15, 1'b1));
		send_item(make_item(MODE_UNUSED, 4'd9, 1'b1));
		send_item(make_item(MODE_SET, 4'd0, 1'b1));
		send_item(make_item(MODE_SET, 4'd15, 1'b0));
	endtask

	task automatic test_dispatch();
		send_item(make_item(MODE_ADD, 4'd0, 1'b1));
		send_item(make_item(MODE_ADD, 4'd15, 1'b0));
		send_item(make_item(MODE_ADD, 4'd7, 1'b0));
		send_item(make_item(MODE_TICK, 4'd0, 1'b0));
		send_item(make_item(MODE_SET, 4'd1, 1'b1));
		send_item(make_item(MODE_SET, 4'd0, 1'b0));
		send_item(make_item(MODE_TICK, 4'd0, 1'b0));
		send_item(make_item(MODE_TICK, 4'd0, 1'b0));
		send_item(make_item(MODE_SET, 4'd1, 1'b0));
		send_item(make_item(MODE_TICK, 4'd0, 1'b0));
		send_item(make_item(MODE_SET, 4'd2, 1'b1));
		send_item(make_item(MODE_SET, 4'd3, 1'b1));
		send_item(make_item(MODE_TICK, 4'd0, 1'b0));
	endtask

	task automatic test_quantum_extremes();
		write_quantum(8'd0);
		send_item(make_item(MODE_SET, 4'd0, 1'b1));
		repeat (3) send_item(make_item(MODE_TICK, 4'd0, 1'b0));
		write_quantum(8'd255);
		repeat (2) send_item(make_item(MODE_TICK, 4'd0, 1'b0));
	endtask

	task automatic run_phase(input logic [QUANT_W-1:0] q, input int ready_pct,
			input int count, input bit no_idle);
		item_t it;
		int r;
		int add_pct;
		write_quantum(q);
		burst_mode <= no_idle;
		for (int i = 0; i < count; i++) begin
			r = $urandom_range(0, 99);
			add_pct = (task_cnt < TASK_SLOTS) ? 12 : 4;
			it.slot = IN_SLOT_W'($urandom_range(0, 15));
			it.ready_flag = ($urandom_range(0, 99) < ready_pct);
			if (r < 1) begin
				it.mode = MODE_UNUSED;
			end else if (r < 1 + add_pct) begin
				it.mode = MODE_ADD;
			end else if (r < 50) begin
				it.mode = MODE_SET;
				if (task_cnt != 0 && $urandom_range(0, 9) != 0)
					it.slot = IN_SLOT_W'($urandom_range(0, task_cnt - 1));
			end else begin
				it.mode = MODE_TICK;
			end
			send_item(it);
			if ($urandom_range(0, 199) == 0)
				wait_drained(1);
		end
	endtask

	task automatic test_random_traffic();
		run_phase(8'd1, 50, 250, 1'b0);
		run_phase(8'd0, 20, 250, 1'b0);
		run_phase(8'd255, 60, 200, 1'b0);
		run_phase(8'd2, 5, 250, 1'b0);
		run_phase(QUANT_W'($urandom_range(3, 12)), 40, 300, 1'b1);
		run_phase(8'd3, 70, 250, 1'b0);
	endtask

	always @(posedge clk) begin
		if (stall_left != 0) begin
			stall_left <= stall_left - 1;
			out_ready <= 1'b0;
		end else if (burst_mode || $urandom_range(0, 99) < 60) begin
			out_ready <= 1'b1;
		end else begin
			out_ready <= 1'b0;
			stall_left <= pick_delay();
		end
	end

	always @(posedge clk) begin
		res_t want;
		if (arst_n && out_valid && out_ready) begin
			if (due_replies.size() == 0) begin
				report_mismatch("unexpected result, task_index", task_index, 0);
			end else begin
				want = due_replies.pop_front();
				if (task_index !== want.task_index)
					report_mismatch("task_index", task_index, want.task_index);
				if (dispatched !== want.dispatched)
					report_mismatch("dispatched", dispatched, want.dispatched);
				if (none_ready !== want.none_ready)
					report_mismatch("none_ready", none_ready, want.none_ready);
				if (rejected !== want.rejected)
					report_mismatch("rejected", rejected, want.rejected);
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready)
				|| (cfg_valid && cfg_ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	initial begin
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_empty_table();
		test_dispatch();
		test_quantum_extremes();
		test_random_traffic();
		wait_drained(TAIL_CYCLES);
		if (error_count == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
